// File: rtl/core/psnr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Polyphonic sine note renderer package
// Shared types, codes and constant tables of the note renderer.
// ----------------------------------------------------------------------------
package psnr_pkg;

  localparam int SPB_W = 18;
  localparam int VOL_W = 15;
  localparam int CFG_W = 18;

  localparam logic [SPB_W-1:0] SPB_RESET = 18'd22050;
  localparam logic [VOL_W-1:0] VOL_RESET = 15'd3932;

  localparam logic CFG_SPB = 1'b0;
  localparam logic CFG_VOL = 1'b1;

  typedef enum logic [1:0] {
    CMD_LOAD  = 2'd0,
    CMD_TICK  = 2'd1,
    CMD_CLEAR = 2'd2
  } cmd_e;

  typedef enum logic [4:0] {
    OP_IDLE,
    OP_LOAD,
    OP_CLEAR,
    OP_BND,
    OP_ACT,
    OP_PH,
    OP_ENV,
    OP_GAIN,
    OP_MUL1,
    OP_MUL2,
    OP_DIV,
    OP_ACC,
    OP_SC0,
    OP_SC1,
    OP_EXP_P,
    OP_EXP_Q,
    OP_EXP_C,
    OP_SC2,
    OP_DSTEP,
    OP_SC3
  } dp_op_e;

  typedef struct packed {
    dp_op_e op;
    logic   cap;
    logic   push;
  } dp_ctrl_t;

  typedef struct packed {
    logic empty;
    logic last;
    logic on;
    logic exp_last;
    logic div_last;
  } dp_stat_t;

  typedef struct packed {
    logic [23:0] start;
    logic [23:0] len;
    logic [6:0]  pitch;
    logic [6:0]  vel;
  } note_t;

  localparam logic [11:0] ATT_LEN = 12'd441;
  localparam logic [11:0] REL_LEN = 12'd3528;
  localparam logic [15:0] FULL_GAIN = 16'd32768;
  localparam logic [39:0] ATT_RECIP = 40'((64'd1 << 47) / 64'd441);
  localparam logic [39:0] REL_RECIP = 40'((64'd1 << 47) / 64'd3528);
  localparam logic [25:0] VEL_RECIP = 26'((64'd1 << 32) / 64'd127);
  localparam logic [6:0]  VEL_MAX = 7'd127;

  localparam logic [18:0] CLIP_LIMIT = 19'd294912;
  localparam logic [16:0] W_GAIN = 17'd94548;
  localparam logic [14:0] LN2_Q15 = 15'd22713;
  localparam logic [30:0] ONE_Q30 = 31'h4000_0000;
  localparam logic [2:0]  EXP_ORDER = 3'd6;
  localparam logic [32:0] RECIP1 = 33'h1_0000_0000;
  localparam logic [32:0] RECIP2 = 33'((64'd1 << 32) / 64'd2);
  localparam logic [32:0] RECIP3 = 33'((64'd1 << 32) / 64'd3);
  localparam logic [32:0] RECIP4 = 33'((64'd1 << 32) / 64'd4);
  localparam logic [32:0] RECIP5 = 33'((64'd1 << 32) / 64'd5);
  localparam logic [32:0] RECIP6 = 33'((64'd1 << 32) / 64'd6);
  localparam logic [15:0] MAG_MAX = 16'd32767;

  localparam logic [31:0] OCT_INC [12] = '{
    32'd685636503, 32'd726406570, 32'd769600953, 32'd815363807,
    32'd863847862, 32'd915214929, 32'd969636441, 32'd1027294024,
    32'd1088380106, 32'd1153098554, 32'd1221665362, 32'd1294309365
  };

  typedef logic [31:0] inc_tab_t [128];

  function automatic inc_tab_t build_inc_tab();
    inc_tab_t    tab;
    int          k;
    int          oct;
    int          o;
    logic [63:0] v;
    k   = 3;
    oct = 0;
    for (int p = 0; p < 128; p++) begin
      o = 10 - oct;
      if (o == 0) begin
        tab[7'(p)] = OCT_INC[4'(k)];
      end else begin
        v = (64'(OCT_INC[4'(k)]) + (64'd1 << (o - 1))) >> o;
        tab[7'(p)] = v[31:0];
      end
      k = k + 1;
      if (k == 12) begin
        k   = 0;
        oct = oct + 1;
      end
    end
    return tab;
  endfunction

  localparam inc_tab_t INC_TAB = build_inc_tab();

  function automatic logic [32:0] exp_recip(input logic [2:0] d);
    logic [32:0] r;
    case (d)
      3'd1:    r = RECIP1;
      3'd2:    r = RECIP2;
      3'd3:    r = RECIP3;
      3'd4:    r = RECIP4;
      3'd5:    r = RECIP5;
      3'd6:    r = RECIP6;
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

// File: rtl/core/psnr_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Note renderer controller
// Sequences loads, clears, the per-note mixing steps, the soft clip and the
// hand-over of each result word to the output register.
// ----------------------------------------------------------------------------
module psnr_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [1:0]         cmd_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output psnr_pkg::dp_ctrl_t ctrl_o,
  input  psnr_pkg::dp_stat_t stat_i
);
  import psnr_pkg::*;

  typedef enum logic [4:0] {
    ST_IDLE, ST_LOAD, ST_CLR, ST_RD, ST_BND, ST_ACT, ST_PH, ST_ENV, ST_GAIN,
    ST_MUL1, ST_MUL2, ST_DIV, ST_ACC, ST_SC0, ST_SC1, ST_EXP_P, ST_EXP_Q,
    ST_EXP_C, ST_SC2, ST_DSTEP, ST_SC3, ST_FIN
  } state_e;

  state_e state_q;
  logic   out_valid_q;
  logic   accept;
  logic   push;
  dp_op_e op;

  assign in_stall_o  = (state_q != ST_IDLE);
  assign accept      = in_valid_i && (state_q == ST_IDLE);
  assign push        = (state_q == ST_FIN) && (!out_valid_q || !out_stall_i);
  assign out_valid_o = out_valid_q;

  always_comb begin
    case (state_q)
      ST_LOAD:  op = OP_LOAD;
      ST_CLR:   op = OP_CLEAR;
      ST_BND:   op = OP_BND;
      ST_ACT:   op = OP_ACT;
      ST_PH:    op = OP_PH;
      ST_ENV:   op = OP_ENV;
      ST_GAIN:  op = OP_GAIN;
      ST_MUL1:  op = OP_MUL1;
      ST_MUL2:  op = OP_MUL2;
      ST_DIV:   op = OP_DIV;
      ST_ACC:   op = OP_ACC;
      ST_SC0:   op = OP_SC0;
      ST_SC1:   op = OP_SC1;
      ST_EXP_P: op = OP_EXP_P;
      ST_EXP_Q: op = OP_EXP_Q;
      ST_EXP_C: op = OP_EXP_C;
      ST_SC2:   op = OP_SC2;
      ST_DSTEP: op = OP_DSTEP;
      ST_SC3:   op = OP_SC3;
      default:  op = OP_IDLE;
    endcase
  end

  assign ctrl_o = '{op: op, cap: accept, push: push};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      if (push) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (accept) begin
            case (cmd_i)
              CMD_LOAD:  state_q <= ST_LOAD;
              CMD_TICK:  state_q <= stat_i.empty ? ST_SC0 : ST_RD;
              CMD_CLEAR: state_q <= ST_CLR;
              default:   state_q <= ST_FIN;
            endcase
          end
        end
        ST_LOAD:  state_q <= ST_FIN;
        ST_CLR:   state_q <= ST_FIN;
        ST_RD:    state_q <= ST_BND;
        ST_BND:   state_q <= ST_ACT;
        ST_ACT: begin
          if (stat_i.on) begin
            state_q <= ST_PH;
          end else begin
            state_q <= stat_i.last ? ST_SC0 : ST_RD;
          end
        end
        ST_PH:    state_q <= ST_ENV;
        ST_ENV:   state_q <= ST_GAIN;
        ST_GAIN:  state_q <= ST_MUL1;
        ST_MUL1:  state_q <= ST_MUL2;
        ST_MUL2:  state_q <= ST_DIV;
        ST_DIV:   state_q <= ST_ACC;
        ST_ACC:   state_q <= stat_i.last ? ST_SC0 : ST_RD;
        ST_SC0:   state_q <= ST_SC1;
        ST_SC1:   state_q <= ST_EXP_P;
        ST_EXP_P: state_q <= ST_EXP_Q;
        ST_EXP_Q: state_q <= ST_EXP_C;
        ST_EXP_C: state_q <= stat_i.exp_last ? ST_SC2 : ST_EXP_P;
        ST_SC2:   state_q <= ST_DSTEP;
        ST_DSTEP: state_q <= stat_i.div_last ? ST_SC3 : ST_DSTEP;
        ST_SC3:   state_q <= ST_FIN;
        ST_FIN: begin
          if (push) begin
            state_q <= ST_IDLE;
          end
        end
        default:  state_q <= ST_IDLE;
      endcase
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni) push |=> out_valid_q)
    else $error("result word lost at hand-over");

  assert property (@(posedge clk_i) disable iff (!rst_ni) accept |=> in_stall_o)
    else $error("new word taken while one is in progress");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && cmd_i == CMD_TICK && stat_i.empty) |=> (state_q == ST_SC0))
    else $error("note walk started on an empty table");

endmodule

// File: rtl/core/psnr_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Note renderer datapath
// Holds the note table, sample clock and configuration, and evaluates one
// note, the soft clip and the final division under controller command.
// ----------------------------------------------------------------------------
module psnr_dp #(
  parameter int MAX_NOTES    = 64,
  parameter int SINE_ENTRIES = 1024
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic                        cfg_index_i,
  input  logic [psnr_pkg::CFG_W-1:0]  cfg_data_i,
  input  logic [23:0]                 start_beats_i,
  input  logic [23:0]                 length_beats_i,
  input  logic [6:0]                  pitch_i,
  input  logic [6:0]                  velocity_i,
  input  psnr_pkg::dp_ctrl_t          ctrl_i,
  output psnr_pkg::dp_stat_t          stat_o,
  output logic signed [15:0]          sample_o,
  output logic                        status_o
);
  import psnr_pkg::*;

  localparam int IDX_W = (MAX_NOTES > 1) ? $clog2(MAX_NOTES) : 1;
  localparam int CNT_W = $clog2(MAX_NOTES + 1);
  localparam int SIN_W = $clog2(SINE_ENTRIES);
  localparam int SUM_W = $clog2(MAX_NOTES) + 17;
  localparam int AX_W  = (SUM_W > 19) ? SUM_W : 19;
  localparam longint ONE_L = 64'sd1073741824;

  typedef logic signed [15:0] sine_rom_t [SINE_ENTRIES];

  function automatic sine_rom_t build_sine();
    sine_rom_t   tab;
    logic [63:0] t;
    logic [1:0]  q;
    longint      u;
    longint      z2;
    longint      p;
    longint      s;
    longint      mag;
    for (int i = 0; i < SINE_ENTRIES; i++) begin
      t = (64'(i) << 32) / 64'(SINE_ENTRIES);
      q = t[31:30];
      u = longint'({34'd0, t[29:0]});
      if (q[0]) begin
        u = ONE_L - u;
      end
      z2 = (u * u) / ONE_L;
      p = 64'sd172272;
      p = -64'sd5026990 + (p * z2) / ONE_L;
      p = 64'sd85569306 + (p * z2) / ONE_L;
      p = -64'sd693598668 + (p * z2) / ONE_L;
      p = 64'sd1686629713 + (p * z2) / ONE_L;
      s = (p * u) / ONE_L;
      if (s < 0) begin
        s = 0;
      end
      if (s > ONE_L) begin
        s = ONE_L;
      end
      mag = (s + 64'sd16384) >>> 15;
      if (mag > 64'sd32767) begin
        mag = 64'sd32767;
      end
      tab[SIN_W'(i)] = q[1] ? -16'(mag) : 16'(mag);
    end
    return tab;
  endfunction

  localparam sine_rom_t SINE_ROM = build_sine();

  logic [SPB_W-1:0]        spb_q;
  logic [VOL_W-1:0]        vol_q;
  note_t                   in_q;
  note_t                   note_mem [MAX_NOTES];
  note_t                   rd_q;
  logic [CNT_W-1:0]        count_q;
  logic [IDX_W-1:0]        idx_q;
  logic [31:0]             clk_q;
  logic [33:0]             s0_q;
  logic [34:0]             s1_q;
  logic [31:0]             inc_q;
  logic [6:0]              vel_q;
  logic [31:0]             loc_q;
  logic                    att_q;
  logic                    shape_q;
  logic [11:0]             envn_q;
  logic [31:0]             phase_q;
  logic [15:0]             envq_q;
  logic [15:0]             env_q;
  logic [SIN_W-1:0]        sidx_q;
  logic signed [15:0]      sin_q;
  logic [21:0]             gain_q;
  logic [30:0]             am_q;
  logic                    neg_q;
  logic [52:0]             big_q;
  logic [15:0]             nq_q;
  logic signed [SUM_W-1:0] sum_q;
  logic                    sneg_q;
  logic                    sat_q;
  logic [20:0]             w_q;
  logic [5:0]              nsh_q;
  logic [29:0]             v_q;
  logic [30:0]             t_q;
  logic [30:0]             y_q;
  logic [30:0]             q0_q;
  logic [2:0]              d_q;
  logic [45:0]             rem_q;
  logic [46:0]             dsh_q;
  logic [15:0]             quo_q;
  logic [3:0]              bcnt_q;
  logic [15:0]             res_sample_q;
  logic                    res_status_q;
  logic [15:0]             sample_q;
  logic                    status_q;

  logic              full;
  logic              on;
  logic [34:0]       clk_w;
  logic [34:0]       loc_full;
  logic [34:0]       dur_w;
  logic [34:0]       rem_w;
  logic [51:0]       envp_w;
  logic [26:0]       env_r;
  logic [11:0]       env_den;
  logic [15:0]       env_fix;
  logic [63:0]       sidx_p;
  logic [14:0]       sin_abs;
  logic [22:0]       n_w;
  logic [48:0]       nqp_w;
  logic [22:0]       nr_w;
  logic [15:0]       mag_fix;
  logic [AX_W-1:0]   ax_w;
  logic [35:0]       wp_w;
  logic [60:0]       yp_w;
  logic [63:0]       q0p_w;
  logic [30:0]       tr_w;
  logic [30:0]       tq_w;
  logic [30:0]       e_w;
  logic [31:0]       den_w;
  logic [45:0]       num_w;
  logic              ge_w;
  logic [15:0]       mag_out;

  assign full     = (count_q == CNT_W'(MAX_NOTES));
  assign clk_w    = {3'b000, clk_q};
  assign on       = (clk_w >= {1'b0, s0_q}) && (clk_w < s1_q);
  assign loc_full = clk_w - {1'b0, s0_q};
  assign dur_w    = s1_q - {1'b0, s0_q};
  assign rem_w    = dur_w - {3'b000, loc_full[31:0]};

  assign envp_w  = 52'(envn_q) * 52'(att_q ? ATT_RECIP : REL_RECIP);
  assign env_den = att_q ? ATT_LEN : REL_LEN;
  assign env_r   = (27'(envn_q) << 15) - 27'(envq_q) * 27'(env_den);
  assign env_fix = envq_q + 16'(env_r >= 27'(env_den));
  assign sidx_p  = (64'(phase_q) * 64'(SINE_ENTRIES)) >> 32;
  assign sin_abs = sin_q[15] ? 15'(-sin_q) : sin_q[14:0];

  assign n_w     = big_q[52:30];
  assign nqp_w   = 49'(n_w) * 49'(VEL_RECIP);
  assign nr_w    = n_w - 23'(nq_q) * 23'(VEL_MAX);
  assign mag_fix = nq_q + 16'(nr_w >= 23'(VEL_MAX));

  assign ax_w    = sum_q[SUM_W-1] ? AX_W'(-sum_q) : AX_W'(sum_q);
  assign wp_w    = 36'(ax_w[18:0]) * 36'(W_GAIN) + 36'd16384;
  assign yp_w    = 61'(v_q) * 61'(t_q);
  assign q0p_w   = 64'(y_q) * 64'(exp_recip(d_q));
  assign tr_w    = y_q - 31'(q0_q * 31'(d_q));
  assign tq_w    = q0_q + 31'(tr_w >= 31'(d_q));
  assign e_w     = t_q >> nsh_q;
  assign den_w   = 32'(ONE_Q30) + 32'(e_w);
  assign num_w   = (46'(ONE_Q30 - e_w) << 15) + 46'(den_w >> 1);
  assign ge_w    = ({1'b0, rem_q} >= dsh_q);
  assign mag_out = (sat_q || quo_q > MAG_MAX) ? MAG_MAX : quo_q;

  assign stat_o = '{
    empty:    (count_q == '0),
    last:     ((CNT_W'(idx_q) + CNT_W'(1)) == count_q),
    on:       on,
    exp_last: (d_q == 3'd1),
    div_last: (bcnt_q == 4'd0)
  };

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      spb_q   <= SPB_RESET;
      vol_q   <= VOL_RESET;
      count_q <= '0;
      clk_q   <= '0;
      idx_q   <= '0;
      d_q     <= EXP_ORDER;
      bcnt_q  <= '0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          CFG_SPB: spb_q <= cfg_data_i;
          CFG_VOL: vol_q <= cfg_data_i[VOL_W-1:0];
          default: spb_q <= spb_q;
        endcase
      end
      if (ctrl_i.cap) begin
        idx_q <= '0;
      end
      case (ctrl_i.op)
        OP_LOAD: begin
          if (!full) begin
            count_q <= count_q + CNT_W'(1);
          end
        end
        OP_CLEAR: begin
          count_q <= '0;
          clk_q   <= '0;
        end
        OP_ACT: begin
          if (!on) begin
            idx_q <= idx_q + IDX_W'(1);
          end
        end
        OP_ACC:   idx_q <= idx_q + IDX_W'(1);
        OP_SC1:   d_q <= EXP_ORDER;
        OP_EXP_C: d_q <= d_q - 3'd1;
        OP_SC2:   bcnt_q <= 4'd15;
        OP_DSTEP: bcnt_q <= bcnt_q - 4'd1;
        OP_SC3: begin
          if (clk_q != '1) begin
            clk_q <= clk_q + 32'd1;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    rd_q  <= note_mem[idx_q];
    sin_q <= SINE_ROM[sidx_q];
    if (ctrl_i.op == OP_LOAD && !full) begin
      note_mem[count_q[IDX_W-1:0]] <= in_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.cap) begin
      in_q         <= '{start: start_beats_i, len: length_beats_i,
                        pitch: pitch_i, vel: velocity_i};
      sum_q        <= '0;
      res_sample_q <= '0;
      res_status_q <= 1'b0;
    end
    if (ctrl_i.push) begin
      sample_q <= res_sample_q;
      status_q <= res_status_q;
    end
    case (ctrl_i.op)
      OP_LOAD: res_status_q <= full;
      OP_BND: begin
        s0_q  <= 34'((42'(rd_q.start) * 42'(spb_q)) >> 8);
        s1_q  <= 35'((43'(25'(rd_q.start) + 25'(rd_q.len)) * 43'(spb_q)) >> 8);
        inc_q <= INC_TAB[rd_q.pitch];
        vel_q <= rd_q.vel;
      end
      OP_ACT: begin
        loc_q   <= loc_full[31:0];
        att_q   <= (loc_full[31:0] < 32'(ATT_LEN));
        shape_q <= (loc_full[31:0] < 32'(ATT_LEN)) || (rem_w < 35'(REL_LEN));
        envn_q  <= (loc_full[31:0] < 32'(ATT_LEN)) ? loc_full[11:0] : rem_w[11:0];
      end
      OP_PH: begin
        phase_q <= 32'(64'(loc_q) * 64'(inc_q));
        envq_q  <= envp_w[47:32];
      end
      OP_ENV: begin
        env_q  <= shape_q ? env_fix : FULL_GAIN;
        sidx_q <= SIN_W'(sidx_p);
      end
      OP_GAIN: gain_q <= 22'(vel_q) * 22'(vol_q);
      OP_MUL1: begin
        am_q  <= 31'(sin_abs) * 31'(env_q);
        neg_q <= sin_q[15];
      end
      OP_MUL2: big_q <= 53'(am_q) * 53'(gain_q);
      OP_DIV:  nq_q <= nqp_w[47:32];
      OP_ACC:  sum_q <= neg_q ? sum_q - SUM_W'(mag_fix) : sum_q + SUM_W'(mag_fix);
      OP_SC0: begin
        sneg_q <= sum_q[SUM_W-1];
        sat_q  <= (ax_w >= AX_W'(CLIP_LIMIT));
        w_q    <= wp_w[35:15];
      end
      OP_SC1: begin
        nsh_q <= w_q[20:15];
        v_q   <= 30'(w_q[14:0]) * 30'(LN2_Q15);
        t_q   <= ONE_Q30;
      end
      OP_EXP_P: y_q <= yp_w[60:30];
      OP_EXP_Q: q0_q <= q0p_w[62:32];
      OP_EXP_C: t_q <= ONE_Q30 - tq_w;
      OP_SC2: begin
        rem_q <= num_w;
        dsh_q <= 47'(den_w) << 15;
        quo_q <= '0;
      end
      OP_DSTEP: begin
        if (ge_w) begin
          rem_q <= rem_q - dsh_q[45:0];
        end
        quo_q <= {quo_q[14:0], ge_w};
        dsh_q <= dsh_q >> 1;
      end
      OP_SC3: res_sample_q <= sneg_q ? -mag_out : mag_out;
      default: quo_q <= quo_q;
    endcase
  end

  assign sample_o = sample_q;
  assign status_o = status_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni) count_q <= CNT_W'(MAX_NOTES))
    else $error("note count beyond table size");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctrl_i.op != OP_CLEAR) |=> (clk_q >= $past(clk_q)))
    else $error("sample clock went backwards without a clear");

endmodule

// File: rtl/core/polyphonic_sine_note_renderer_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Polyphonic sine note renderer
// Channel | Signals                                              | Dir
// input   | in_valid_i, in_stall_o, cmd_i, start_beats_i,        | in
//         | length_beats_i, pitch_i, velocity_i                  |
// output  | out_valid_o, out_stall_i, sample_o, status_o         | out
// config  | cfg_we_i, cfg_index_i, cfg_data_i                    | in
//
// A load or clear passes through its own step state and the finish state, the
// unused command straight to it. A tick walks each note through the per-note
// step sequence over the note table, silent notes leaving early, then the
// sixth-order exponential series and 16-bit restoring divider of the soft clip.
// Reset empties the table and zeroes the sample clock with no clearing pass.
// A waiting result word is held in the output register while a new word is
// taken; a finished word waits only while that register is full and stalled.
// ----------------------------------------------------------------------------
module polyphonic_sine_note_renderer_top #(
  parameter int MAX_NOTES    = 64,
  parameter int SINE_ENTRIES = 1024
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic                       cfg_index_i,
  input  logic [psnr_pkg::CFG_W-1:0] cfg_data_i,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic [1:0]                 cmd_i,
  input  logic [23:0]                start_beats_i,
  input  logic [23:0]                length_beats_i,
  input  logic [6:0]                 pitch_i,
  input  logic [6:0]                 velocity_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic signed [15:0]         sample_o,
  output logic                       status_o
);
  import psnr_pkg::*;

  dp_ctrl_t ctrl;
  dp_stat_t stat;

  psnr_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .cmd_i       (cmd_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .ctrl_o      (ctrl),
    .stat_i      (stat)
  );

  psnr_dp #(
    .MAX_NOTES    (MAX_NOTES),
    .SINE_ENTRIES (SINE_ENTRIES)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .start_beats_i  (start_beats_i),
    .length_beats_i (length_beats_i),
    .pitch_i        (pitch_i),
    .velocity_i     (velocity_i),
    .ctrl_i         (ctrl),
    .stat_o         (stat),
    .sample_o       (sample_o),
    .status_o       (status_o)
  );

endmodule
